@@ src/xxh64_pkg.sv @@
// package for the xxhash64 stream hash unit: primes and shared types
package xxh64_pkg;

    localparam logic [63:0] XP1 = 64'd11400714785074694791;
    localparam logic [63:0] XP2 = 64'd14029467366897019727;
    localparam logic [63:0] XP3 = 64'd1609587929392839161;
    localparam logic [63:0] XP4 = 64'd9650029242287828579;
    localparam logic [63:0] XP5 = 64'd2870177450012600261;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned PART_W  = 32;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t rotl(input word_t x, input int unsigned r);
        rotl = (x << r) | (x >> (WORD_W - r));
    endfunction

endpackage

@@ src/xxh64_mul.sv @@
// sequential 64x64 low-half multiplier built from one 32x32 partial product per cycle
module xxh64_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  xxh64_pkg::word_t    a,
    input  xxh64_pkg::word_t    b,
    output logic                done,
    output xxh64_pkg::word_t    product
);
    import xxh64_pkg::*;

    logic [1:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    word_t             a_reg, a_next, b_reg, b_next;
    word_t             acc_reg, acc_next;
    logic [PART_W-1:0] op_x, op_y;
    logic [2*PART_W-1:0] pp_reg;
    logic              pp_vld_reg;
    logic [1:0]        pp_step_reg;

    always_comb
    begin
        case (step_reg)
            2'd0:    begin op_x = a_reg[31:0];  op_y = b_reg[31:0];  end
            2'd1:    begin op_x = a_reg[63:32]; op_y = b_reg[31:0];  end
            default: begin op_x = a_reg[31:0];  op_y = b_reg[63:32]; end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            step_next = 2'd0;
            busy_next = 1'b1;
            acc_next  = '0;
        end
        else
        begin
            if (busy_reg)
            begin
                if (step_reg == 2'd2)
                    busy_next = 1'b0;
                else
                    step_next = step_reg + 2'd1;
            end
            if (pp_vld_reg)
            begin
                if (pp_step_reg == 2'd0)
                    acc_next = acc_reg + pp_reg;
                else
                    acc_next = acc_reg + {pp_reg[31:0], 32'd0};
                if (pp_step_reg == 2'd2)
                    done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_step_reg <= '0;
        end
        else
        begin
            step_reg    <= step_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            pp_vld_reg  <= busy_reg && !start;
            pp_step_reg <= step_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        pp_reg  <= op_x * op_y;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ src/xxhash64_stream_hash_unit.sv @@
// xxhash64 stream hash unit: top level with sequencer and shared multiplier
// Computes the 64-bit xxHash of a message fed as little-endian 64-bit words, seed from the
// configuration channel. Every multiplication runs on one shared 64-bit multiplier built from
// three pipelined 32x32 partial products; a multiply starts only once the product before it
// is back. A word held back in the tail needs no multiply, a word that completes a stripe
// eight dependent multiplies and the last word at worst 31 multiplies (lane merge, tail
// folding and avalanche). in_ready is low while a word is being processed. The digest is
// held in an output register: a word that is not last is taken while it waits, a last word
// waits until the digest has been taken.
module xxhash64_stream_hash_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  xxh64_pkg::word_t              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  xxh64_pkg::word_t              data_word,
    input  logic [xxh64_pkg::COUNT_W-1:0] byte_count,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output xxh64_pkg::word_t              digest
);
    import xxh64_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_STRIPE = 8'b0000_0010,
        S_MERGE  = 8'b0000_0100,
        S_TAIL8  = 8'b0000_1000,
        S_TAIL4  = 8'b0001_0000,
        S_TAIL1  = 8'b0010_0000,
        S_AVAL   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic        wait_reg, wait_next;
    word_t       seed_reg;
    word_t       lane_reg [4];
    word_t       tail_reg [3];
    logic [1:0]  pos_reg, pos_next;
    word_t       len_reg, len_next;
    word_t       h_reg, h_next;
    word_t       t_reg, t_next;
    word_t       w_reg, w_next;
    logic [3:0]  bc_reg, bc_next;
    logic [1:0]  idx_reg, idx_next;
    word_t       dig_reg;
    logic        ov_reg, ov_next;
    logic        lane_we;
    word_t       lane_wd;
    logic        lanes_load;
    logic        tail_we;

    logic  mul_start;
    word_t mul_a, mul_b, mul_p;
    logic  mul_done;

    xxh64_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    logic  acc_word;
    logic [3:0] bc_sat;
    logic  first_stripe;
    assign acc_word  = in_valid && in_ready;
    assign bc_sat    = (byte_count > 4'd8) ? 4'd8 : byte_count;
    assign first_stripe = (len_reg == 64'd24);

    assign in_ready  = (state_reg == S_IDLE) && !(ov_reg && !out_ready && last);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign digest    = dig_reg;

    function automatic word_t lane_start(input word_t s, input logic [1:0] i);
        case (i)
            2'd0:    lane_start = s + XP1 + XP2;
            2'd1:    lane_start = s + XP2;
            2'd2:    lane_start = s;
            default: lane_start = s - XP1;
        endcase
    endfunction

    // one multiply per op; wait_reg marks a pending product
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        wait_next  = wait_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        h_next     = h_reg;
        t_next     = t_reg;
        w_next     = w_reg;
        bc_next    = bc_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ready;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        lane_we    = 1'b0;
        lane_wd    = t_reg;
        lanes_load = 1'b0;
        tail_we    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (acc_word)
                begin
                    w_next   = data_word;
                    op_next  = '0;
                    idx_next = '0;
                    if (!last || bc_sat == 4'd8)
                    begin
                        len_next = len_reg + 64'd8;
                        if (pos_reg != 2'd3)
                        begin
                            tail_we  = 1'b1;
                            pos_next = pos_reg + 2'd1;
                            bc_next  = 4'd0;
                            state_next = last ? S_MERGE : S_IDLE;
                        end
                        else
                        begin
                            if (first_stripe)
                                lanes_load = 1'b1;
                            bc_next    = 4'd0;
                            state_next = S_STRIPE;
                            wait_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        len_next   = len_reg + {60'd0, bc_sat};
                        bc_next    = bc_sat;
                        state_next = S_MERGE;
                    end
                    h_next = {63'd0, last};
                end
            end

            // per lane: t = v*P2; t = rotl(acc+t,31)*P1
            S_STRIPE:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                    if (!op_reg[0])
                    begin
                        mul_a = (idx_reg == 2'd3) ? w_reg : tail_reg[idx_reg];
                        mul_b = XP2;
                    end
                    else
                    begin
                        mul_a = rotl(lane_reg[idx_reg] + t_reg, 31);
                        mul_b = XP1;
                    end
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    t_next    = mul_p;
                    op_next   = op_reg + 4'd1;
                    if (op_reg[0])
                    begin
                        lane_we  = 1'b1;
                        lane_wd  = mul_p;
                        idx_next = idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            pos_next   = '0;
                            state_next = h_reg[0] ? S_MERGE : S_IDLE;
                            op_next    = '0;
                            idx_next   = '0;
                        end
                    end
                end
            end

            // op0: start, then per lane: v*P2, rotl*P1, (h^x)*P1
            S_MERGE:
            begin
                if (op_reg == 4'd0)
                begin
                    if (len_reg >= 64'd32)
                    begin
                        h_next  = rotl(lane_reg[0], 1) + rotl(lane_reg[1], 7) +
                                  rotl(lane_reg[2], 12) + rotl(lane_reg[3], 18);
                        op_next = 4'd1;
                    end
                    else
                    begin
                        h_next     = seed_reg + XP5 + len_reg;
                        state_next = S_TAIL8;
                        op_next    = '0;
                    end
                    idx_next  = '0;
                    wait_next = 1'b0;
                end
                else if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                    case (op_reg)
                        4'd1:
                        begin
                            mul_a = lane_reg[idx_reg];
                            mul_b = XP2;
                        end
                        4'd2:
                        begin
                            mul_a = rotl(t_reg, 31);
                            mul_b = XP1;
                        end
                        default:
                        begin
                            mul_a = h_reg ^ t_reg;
                            mul_b = XP1;
                        end
                    endcase
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    t_next    = mul_p;
                    op_next   = op_reg + 4'd1;
                    if (op_reg == 4'd3)
                    begin
                        h_next   = mul_p + XP4;
                        op_next  = 4'd1;
                        idx_next = idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            h_next     = mul_p + XP4 + len_reg;
                            state_next = S_TAIL8;
                            op_next    = '0;
                            idx_next   = '0;
                        end
                    end
                end
            end

            S_TAIL8:
            begin
                if (idx_reg == pos_reg)
                begin
                    state_next = (bc_reg >= 4'd4) ? S_TAIL4 : S_TAIL1;
                    op_next    = '0;
                end
                else if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                    case (op_reg)
                        4'd0:
                        begin
                            mul_a = tail_reg[idx_reg];
                            mul_b = XP2;
                        end
                        4'd1:
                        begin
                            mul_a = rotl(t_reg, 31);
                            mul_b = XP1;
                        end
                        default:
                        begin
                            mul_a = rotl(h_reg ^ t_reg, 27);
                            mul_b = XP1;
                        end
                    endcase
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    t_next    = mul_p;
                    op_next   = op_reg + 4'd1;
                    if (op_reg == 4'd2)
                    begin
                        h_next   = mul_p + XP4;
                        op_next  = '0;
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end

            S_TAIL4:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                    if (op_reg == 4'd0)
                    begin
                        mul_a = {32'd0, w_reg[31:0]};
                        mul_b = XP1;
                    end
                    else
                    begin
                        mul_a = rotl(h_reg ^ t_reg, 23);
                        mul_b = XP2;
                    end
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    t_next    = mul_p;
                    op_next   = op_reg + 4'd1;
                    if (op_reg == 4'd1)
                    begin
                        h_next     = mul_p + XP3;
                        w_next     = w_reg >> 32;
                        bc_next    = bc_reg - 4'd4;
                        op_next    = '0;
                        state_next = S_TAIL1;
                    end
                end
            end

            S_TAIL1:
            begin
                if (bc_reg == 4'd0)
                begin
                    state_next = S_AVAL;
                    op_next    = '0;
                end
                else if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                    if (op_reg == 4'd0)
                    begin
                        mul_a = {56'd0, w_reg[7:0]};
                        mul_b = XP5;
                    end
                    else
                    begin
                        mul_a = rotl(h_reg ^ t_reg, 11);
                        mul_b = XP1;
                    end
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    t_next    = mul_p;
                    op_next   = op_reg + 4'd1;
                    if (op_reg == 4'd1)
                    begin
                        h_next  = mul_p;
                        w_next  = w_reg >> 8;
                        bc_next = bc_reg - 4'd1;
                        op_next = '0;
                    end
                end
            end

            S_AVAL:
            begin
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                    if (op_reg == 4'd0)
                    begin
                        mul_a = h_reg ^ (h_reg >> 33);
                        mul_b = XP2;
                    end
                    else
                    begin
                        mul_a = h_reg ^ (h_reg >> 29);
                        mul_b = XP3;
                    end
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    h_next    = mul_p;
                    op_next   = op_reg + 4'd1;
                    if (op_reg == 4'd1)
                        state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    lanes_load = 1'b1;
                    pos_next   = '0;
                    len_next   = '0;
                    op_next    = '0;
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            wait_reg  <= 1'b0;
            pos_reg   <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            bc_reg    <= '0;
            ov_reg    <= 1'b0;
            seed_reg  <= '0;
            for (int i = 0; i < 4; i++)
                lane_reg[i] <= lane_start('0, 2'(i));
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            wait_reg  <= wait_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            bc_reg    <= bc_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready)
                seed_reg <= cfg_data;
            if (lanes_load)
            begin
                for (int i = 0; i < 4; i++)
                    lane_reg[i] <= lane_start(seed_reg, 2'(i));
            end
            else if (lane_we)
                lane_reg[idx_reg] <= lane_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        t_reg <= t_next;
        w_reg <= w_next;
        if (tail_we)
            tail_reg[pos_reg] <= data_word;
        if (state_reg == S_EMIT && (!ov_reg || out_ready))
            dig_reg <= h_reg ^ (h_reg >> 32);
    end

endmodule
